>>> rtl/core/lagb_pkg.sv
package lagb_pkg;

    // input actions
    localparam logic [1:0] ACT_WRITE_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_WRITE_LABEL  = 2'd1;
    localparam logic [1:0] ACT_WRITE_WEIGHT = 2'd2;
    localparam logic [1:0] ACT_QUERY        = 2'd3;

    // result status codes
    localparam logic [1:0] ST_WRITE_DONE = 2'd0;
    localparam logic [1:0] ST_RESULT     = 2'd1;
    localparam logic [1:0] ST_BAD_COORD  = 2'd2;
    localparam logic [1:0] ST_ZERO_SUM   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef logic signed [23:0] sample_t;

endpackage

>>> rtl/core/lagb_ram.sv
module lagb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/label_aware_gaussian_blur_core.sv
// Label-aware Gaussian blur core.
// Input channel (in_valid/in_ready) carries one transaction per action:
// sample, label or weight writes, or a query of the blurred value at a
// pixel and channel. Output channel (out_valid/out_ready) returns exactly
// one transaction per input: a status and the blurred value.
// Configuration (cfg_we/cfg_index/cfg_data) sets rows, columns and radius;
// write it only while the core is idle.
// A write goes from the accepting edge through dispatch to the output state;
// a radius-zero query also passes a state that reads the sample. A query
// with radius R walks up to (2R+1)^2 window entries, with a weight read per
// row, a label check per entry and, per matching entry, two products on one
// shared multiplier and an accumulate; then a restoring divider forms the
// 64-bit quotient bit by bit. One transaction is in work at a time: in_ready
// is high only while the sequencer is idle.
// Reset clears control state and the registers to 64 rows, 64 columns and
// radius zero; the sample, label and weight stores are undefined until
// written. When the receiver stalls, the result holds in the output
// register and the core waits with the next result until it is taken.
module label_aware_gaussian_blur_core #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int CHANNELS   = 2,
    parameter int MAX_RADIUS = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [5:0]            row,
    input  logic [5:0]            col,
    input  logic                  channel,
    input  lagb_pkg::sample_t     sample_value,
    input  logic [7:0]            label,
    input  logic [2:0]            weight_index,
    input  logic [15:0]           weight,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output lagb_pkg::sample_t     blurred_value
);

    import lagb_pkg::*;

    localparam int PIX  = MAX_ROWS * MAX_COLS;
    localparam int SDEP = CHANNELS * PIX;
    localparam int LAW  = $clog2(PIX > 1 ? PIX : 2);
    localparam int SAW  = $clog2(SDEP > 1 ? SDEP : 2);
    localparam int WDEP = MAX_RADIUS + 1;
    localparam int WAW  = $clog2(WDEP);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_PASSW  = 4'd2;
    localparam logic [3:0] S_CENW   = 4'd3;
    localparam logic [3:0] S_ROW    = 4'd4;
    localparam logic [3:0] S_ROWW   = 4'd5;
    localparam logic [3:0] S_ADDR   = 4'd6;
    localparam logic [3:0] S_MUL1   = 4'd7;
    localparam logic [3:0] S_MUL2   = 4'd8;
    localparam logic [3:0] S_ACC    = 4'd9;
    localparam logic [3:0] S_DIVSET = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]  state_reg;
    logic [6:0]  rows_reg, cols_reg;
    logic [2:0]  radius_reg;

    // latched transaction
    logic [1:0]  act_reg;
    logic [6:0]  r_reg, c_reg;
    logic        ch_reg;
    sample_t     sval_reg;
    logic [7:0]  lab_reg;
    logic [2:0]  widx_reg;
    logic [15:0] wval_reg;

    // window walk
    logic [6:0]  rr_reg, cc_reg;
    logic [7:0]  centre_reg;
    logic [15:0] wr_reg;
    sample_t     smp_reg;
    logic signed [58:0] mul_reg;
    logic signed [63:0] acc_reg;
    logic [39:0] wsum_reg;

    // divider
    logic [63:0] dvd_reg;
    logic [40:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;

    // result
    logic [1:0]  res_status_reg;
    sample_t     res_value_reg;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    sample_t     out_value_reg;

    // clamped frame size and radius
    logic [10:0] nrows, ncols;
    logic [3:0]  rad;
    always_comb
    begin
        if (rows_reg == 7'd0)
            nrows = 11'd1;
        else if (11'(rows_reg) > 11'(MAX_ROWS))
            nrows = 11'(MAX_ROWS);
        else
            nrows = 11'(rows_reg);
        if (cols_reg == 7'd0)
            ncols = 11'd1;
        else if (11'(cols_reg) > 11'(MAX_COLS))
            ncols = 11'(MAX_COLS);
        else
            ncols = 11'(cols_reg);
        if (4'(radius_reg) > 4'(MAX_RADIUS))
            rad = 4'(MAX_RADIUS);
        else
            rad = 4'(radius_reg);
    end

    // range checks on the latched coordinates
    logic pix_ok, ch_ok, widx_ok;
    assign pix_ok  = (11'(r_reg) < nrows) && (11'(c_reg) < ncols);
    assign ch_ok   = (3'(ch_reg) < 3'(CHANNELS));
    assign widx_ok = (5'(widx_reg) <= 5'(MAX_RADIUS));

    // clipped window bounds
    logic [6:0] top, left, bot, right, r_far, c_far;
    always_comb
    begin
        top   = (r_reg > 7'(rad)) ? r_reg - 7'(rad) : 7'd0;
        left  = (c_reg > 7'(rad)) ? c_reg - 7'(rad) : 7'd0;
        r_far = r_reg + 7'(rad);
        c_far = c_reg + 7'(rad);
        bot   = (11'(r_far) < nrows - 11'd1) ? r_far : 7'(nrows - 11'd1);
        right = (11'(c_far) < ncols - 11'd1) ? c_far : 7'(ncols - 11'd1);
    end

    // offsets from the centre
    logic [6:0] dr, dc;
    assign dr = (rr_reg > r_reg) ? rr_reg - r_reg : r_reg - rr_reg;
    assign dc = (cc_reg > c_reg) ? cc_reg - c_reg : c_reg - cc_reg;

    // store addresses
    logic [LAW-1:0] laddr;
    logic [SAW-1:0] saddr;
    logic [WAW-1:0] wraddr;
    assign laddr  = LAW'(32'(rr_reg) * MAX_COLS + 32'(cc_reg));
    assign saddr  = SAW'(32'(ch_reg) * PIX + 32'(laddr));
    assign wraddr = (state_reg == S_ROW) ? WAW'(dr) : WAW'(dc);

    logic       s_we, l_we, w_we;
    assign s_we = (state_reg == S_DISP) && (act_reg == ACT_WRITE_SAMPLE) && pix_ok && ch_ok;
    assign l_we = (state_reg == S_DISP) && (act_reg == ACT_WRITE_LABEL) && pix_ok;
    assign w_we = (state_reg == S_DISP) && (act_reg == ACT_WRITE_WEIGHT) && widx_ok;

    logic [23:0] srdata;
    logic [7:0]  lrdata;
    logic [15:0] wrdata;

    lagb_ram #(.WIDTH(24), .DEPTH(SDEP)) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (saddr),
        .wdata (sval_reg),
        .raddr (saddr),
        .rdata (srdata)
    );

    lagb_ram #(.WIDTH(8), .DEPTH(PIX)) u_label_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (laddr),
        .wdata (lab_reg),
        .raddr (laddr),
        .rdata (lrdata)
    );

    lagb_ram #(.WIDTH(16), .DEPTH(WDEP)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (WAW'(widx_reg)),
        .wdata (wval_reg),
        .raddr (wraddr),
        .rdata (wrdata)
    );

    // shared multiplier: weight product, then sample times weight
    logic signed [24:0] mop_a;
    logic signed [33:0] mop_b;
    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mop_a = $signed({9'd0, wr_reg});
            mop_b = $signed({18'd0, wrdata});
        end
        else
        begin
            mop_a = 25'(smp_reg);
            mop_b = $signed({2'd0, mul_reg[31:0]});
        end
    end

    // divider step
    logic [40:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg[39:0], dvd_reg[63]};
    assign q_bit  = (rem_sh >= {1'b0, wsum_reg});

    logic [63:0] mag;
    assign mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);

    logic last_col, last_row;
    assign last_col = (cc_reg == right);
    assign last_row = (rr_reg == bot);

    logic       out_free;
    assign out_free = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 7'd64;
            cols_reg   <= 7'd64;
            radius_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS:   rows_reg   <= cfg_data;
                CFG_COLS:   cols_reg   <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    res_value_reg <= '0;
                    if (act_reg != ACT_QUERY)
                    begin
                        res_status_reg <= (s_we || l_we || w_we) ? ST_WRITE_DONE
                                                                 : ST_BAD_COORD;
                        state_reg <= S_OUT;
                    end
                    else if (!(pix_ok && ch_ok))
                    begin
                        res_status_reg <= ST_BAD_COORD;
                        state_reg <= S_OUT;
                    end
                    else if (rad == 4'd0)
                        state_reg <= S_PASSW;
                    else
                        state_reg <= S_CENW;
                end
                S_PASSW:
                begin
                    res_status_reg <= ST_RESULT;
                    res_value_reg  <= srdata;
                    state_reg      <= S_OUT;
                end
                S_CENW:
                begin
                    centre_reg <= lrdata;
                    rr_reg     <= top;
                    cc_reg     <= left;
                    acc_reg    <= '0;
                    wsum_reg   <= '0;
                    state_reg  <= S_ROW;
                end
                S_ROW:
                    state_reg <= S_ROWW;
                S_ROWW:
                begin
                    wr_reg    <= wrdata;
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                    state_reg <= S_MUL1;
                S_MUL1:
                begin
                    if (lrdata == centre_reg)
                    begin
                        mul_reg   <= 59'(mop_a * mop_b);
                        smp_reg   <= srdata;
                        state_reg <= S_MUL2;
                    end
                    else if (!last_col)
                    begin
                        cc_reg    <= cc_reg + 7'd1;
                        state_reg <= S_ADDR;
                    end
                    else if (!last_row)
                    begin
                        rr_reg    <= rr_reg + 7'd1;
                        cc_reg    <= left;
                        state_reg <= S_ROW;
                    end
                    else
                        state_reg <= S_DIVSET;
                end
                S_MUL2:
                begin
                    wsum_reg  <= wsum_reg + 40'(mul_reg[31:0]);
                    mul_reg   <= 59'(mop_a * mop_b);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_reg + 64'(mul_reg);
                    if (!last_col)
                    begin
                        cc_reg    <= cc_reg + 7'd1;
                        state_reg <= S_ADDR;
                    end
                    else if (!last_row)
                    begin
                        rr_reg    <= rr_reg + 7'd1;
                        cc_reg    <= left;
                        state_reg <= S_ROW;
                    end
                    else
                        state_reg <= S_DIVSET;
                end
                S_DIVSET:
                begin
                    if (wsum_reg == 40'd0)
                    begin
                        res_status_reg <= ST_ZERO_SUM;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        neg_reg   <= acc_reg[63];
                        dvd_reg   <= mag + 64'(wsum_reg >> 1);
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= q_bit ? rem_sh - {1'b0, wsum_reg} : rem_sh;
                    dvd_reg <= {dvd_reg[62:0], q_bit};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    res_status_reg <= ST_RESULT;
                    if (neg_reg)
                        res_value_reg <= (dvd_reg > 64'h80_0000) ? 24'sh80_0000
                                                                 : 24'(-dvd_reg);
                    else
                        res_value_reg <= (dvd_reg > 64'h7F_FFFF) ? 24'sh7F_FFFF
                                                                 : 24'(dvd_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_value_reg  <= res_value_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            // capture the accepted transaction
            if (state_reg == S_IDLE && in_valid)
            begin
                act_reg  <= action;
                r_reg    <= 7'(row);
                c_reg    <= 7'(col);
                rr_reg   <= 7'(row);
                cc_reg   <= 7'(col);
                ch_reg   <= channel;
                sval_reg <= sample_value;
                lab_reg  <= label;
                widx_reg <= weight_index;
                wval_reg <= weight;
            end
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign blurred_value = out_value_reg;

endmodule

>>> rtl/core/lagb_checker.sv
module lagb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        status,
    input lagb_pkg::sample_t blurred_value
);

    import lagb_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(blurred_value))
        else $error("stalled result changed");

    // value is zero unless a query result
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_RESULT |-> blurred_value == 24'sd0)
        else $error("nonzero value with non-result status");

    // one transaction at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // a result never appears the cycle after an accept
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

endmodule

bind label_aware_gaussian_blur_core lagb_checker u_lagb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .blurred_value (blurred_value)
);

>>> bench/tb_label_aware_gaussian_blur_core.sv
module tb_label_aware_gaussian_blur_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lagb_pkg::*;

    typedef struct {
        logic [1:0]  action;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        channel;
        sample_t     sample_value;
        logic [7:0]  label;
        logic [2:0]  weight_index;
        logic [15:0] weight;
    } pixel_op_t;

    typedef struct {
        logic [1:0] status;
        sample_t    blurred_value;
    } blur_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_ROWS;
    logic [6:0]  cfg_data = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_WRITE_SAMPLE;
    logic [5:0]  row = 6'd0;
    logic [5:0]  col = 6'd0;
    logic        channel = 1'b0;
    sample_t     sample_value = '0;
    logic [7:0]  label = 8'd0;
    logic [2:0]  weight_index = 3'd0;
    logic [15:0] weight = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    sample_t     blurred_value;

    label_aware_gaussian_blur_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .row(row), .col(col), .channel(channel),
        .sample_value(sample_value), .label(label),
        .weight_index(weight_index), .weight(weight),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .blurred_value(blurred_value)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the frame, labels, weights and registers
    sample_t      frame_samples [2][64][64];
    logic [7:0]   frame_labels [64][64];
    logic [15:0]  gauss_w [8];
    bit           sample_set [2][64][64];
    bit           label_set [64][64];
    int unsigned  n_rows = 64;
    int unsigned  n_cols = 64;
    int unsigned  win_rad = 0;

    pixel_op_t    pending_ops [$];
    blur_result_t expected_results [$];
    int           error_count = 0;
    int unsigned  cycle_count = 0;
    bit           in_fire = 1'b0;
    int unsigned  stuck_cycles = 0;

    // expected result of one transaction, updating the shadow state
    function automatic blur_result_t blur_predict(pixel_op_t op);
        blur_result_t res;
        int unsigned r, c, top, bot, lft, rgt, dr, dc;
        longint signed acc;
        logic [63:0] wsum, w, mag, q;
        logic [7:0] centre;
        bit pix_ok;
        r = op.row;
        c = op.col;
        pix_ok = (r < n_rows) && (c < n_cols);
        res.status = ST_BAD_COORD;
        res.blurred_value = '0;
        case (op.action)
            ACT_WRITE_SAMPLE:
            begin
                if (pix_ok)
                begin
                    frame_samples[op.channel][r][c] = op.sample_value;
                    sample_set[op.channel][r][c] = 1'b1;
                    res.status = ST_WRITE_DONE;
                end
            end
            ACT_WRITE_LABEL:
            begin
                if (pix_ok)
                begin
                    frame_labels[r][c] = op.label;
                    label_set[r][c] = 1'b1;
                    res.status = ST_WRITE_DONE;
                end
            end
            ACT_WRITE_WEIGHT:
            begin
                gauss_w[op.weight_index] = op.weight;
                res.status = ST_WRITE_DONE;
            end
            default:
            begin
                if (pix_ok && win_rad == 0)
                begin
                    res.status = ST_RESULT;
                    res.blurred_value = frame_samples[op.channel][r][c];
                end
                else if (pix_ok)
                begin
                    centre = frame_labels[r][c];
                    top = (r > win_rad) ? r - win_rad : 0;
                    lft = (c > win_rad) ? c - win_rad : 0;
                    bot = (r + win_rad < n_rows - 1) ? r + win_rad : n_rows - 1;
                    rgt = (c + win_rad < n_cols - 1) ? c + win_rad : n_cols - 1;
                    acc = 0;
                    wsum = 0;
                    for (int unsigned rr = top; rr <= bot; rr++)
                    begin
                        dr = (rr > r) ? rr - r : r - rr;
                        for (int unsigned cc = lft; cc <= rgt; cc++)
                        begin
                            dc = (cc > c) ? cc - c : c - cc;
                            if (frame_labels[rr][cc] == centre)
                            begin
                                w = 64'(gauss_w[dr]) * 64'(gauss_w[dc]);
                                acc += longint'(frame_samples[op.channel][rr][cc])
                                       * longint'(w);
                                wsum += w;
                            end
                        end
                    end
                    if (wsum == 0)
                    begin
                        res.status = ST_ZERO_SUM;
                    end
                    else
                    begin
                        res.status = ST_RESULT;
                        mag = (acc < 0) ? -acc : acc;
                        q = (mag + wsum / 2) / wsum;
                        if (acc < 0)
                        begin
                            if (q > 64'h800000)
                                q = 64'h800000;
                            res.blurred_value = sample_t'(-q);
                        end
                        else
                        begin
                            if (q > 64'h7fffff)
                                q = 64'h7fffff;
                            res.blurred_value = sample_t'(q);
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic pixel_op_t random_op(logic [1:0] act);
        pixel_op_t op;
        op.action = act;
        op.row = 6'($urandom);
        op.col = 6'($urandom);
        op.channel = 1'($urandom);
        op.sample_value = sample_t'($urandom);
        op.label = 8'($urandom);
        op.weight_index = 3'($urandom);
        op.weight = 16'($urandom);
        return op;
    endfunction

    function automatic logic [7:0] pick_label();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    endfunction

    task automatic push_op(pixel_op_t op);
        expected_results.push_back(blur_predict(op));
        pending_ops.push_back(op);
    endtask

    // fill whatever the window still lacks, then ask for the blurred value
    task automatic window_query(int unsigned r, int unsigned c, bit ch);
        pixel_op_t op;
        int unsigned top, bot, lft, rgt;
        top = (r > win_rad) ? r - win_rad : 0;
        lft = (c > win_rad) ? c - win_rad : 0;
        bot = (r + win_rad < n_rows - 1) ? r + win_rad : n_rows - 1;
        rgt = (c + win_rad < n_cols - 1) ? c + win_rad : n_cols - 1;
        for (int unsigned rr = top; rr <= bot; rr++)
            for (int unsigned cc = lft; cc <= rgt; cc++)
            begin
                if (!label_set[rr][cc])
                begin
                    op = random_op(ACT_WRITE_LABEL);
                    op.row = 6'(rr);
                    op.col = 6'(cc);
                    op.label = pick_label();
                    push_op(op);
                end
                if (!sample_set[ch][rr][cc])
                begin
                    op = random_op(ACT_WRITE_SAMPLE);
                    op.row = 6'(rr);
                    op.col = 6'(cc);
                    op.channel = ch;
                    push_op(op);
                end
            end
        op = random_op(ACT_QUERY);
        op.row = 6'(r);
        op.col = 6'(c);
        op.channel = ch;
        push_op(op);
    endtask

    task automatic load_weights(bit zeros);
        pixel_op_t op;
        for (int i = 0; i < 8; i++)
        begin
            op = random_op(ACT_WRITE_WEIGHT);
            op.weight_index = 3'(i);
            if (zeros)
                op.weight = 16'd0;
            else if ($urandom_range(0, 5) == 0)
                op.weight = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'd1;
            push_op(op);
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 7'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROWS)
            n_rows = val;
        else if (idx == CFG_COLS)
            n_cols = val;
        else
            win_rad = val;
    endtask

    task automatic run_phase(int unsigned nr, int unsigned nc, int unsigned rad,
                             int unsigned budget, bit zero_w);
        pixel_op_t op;
        int unsigned r, c, start;
        wait_drained();
        write_reg(CFG_ROWS, nr);
        write_reg(CFG_COLS, nc);
        write_reg(CFG_RADIUS, rad);
        load_weights(zero_w);
        start = expected_results.size();
        while (pending_ops.size() < budget)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // stray write, sometimes outside the frame in use
                    op = random_op(2'($urandom_range(0, 2)));
                    push_op(op);
                end
                1:
                begin
                    // query with a coordinate off the frame, or a cluster query
                    // when the frame spans the whole store
                    op = random_op(ACT_QUERY);
                    if (nr < 64)
                    begin
                        op.row = 6'($urandom_range(nr, 63));
                        push_op(op);
                    end
                    else if (nc < 64)
                    begin
                        op.col = 6'($urandom_range(nc, 63));
                        push_op(op);
                    end
                    else
                        window_query($urandom_range(0, 9), $urandom_range(0, 9),
                                     op.channel);
                end
                2:
                begin
                    // relabel a cluster pixel
                    op = random_op(ACT_WRITE_LABEL);
                    op.row = 6'($urandom_range(0, (nr < 10 ? nr : 10) - 1));
                    op.col = 6'($urandom_range(0, (nc < 10 ? nc : 10) - 1));
                    op.label = pick_label();
                    push_op(op);
                end
                default:
                begin
                    // centres near the origin, or now and then near the far corner
                    if ($urandom_range(0, 7) == 0)
                    begin
                        r = nr - 1 - $urandom_range(0, (nr < 3 ? nr : 3) - 1);
                        c = nc - 1 - $urandom_range(0, (nc < 3 ? nc : 3) - 1);
                    end
                    else
                    begin
                        r = $urandom_range(0, (nr < 10 ? nr : 10) - 1);
                        c = $urandom_range(0, (nc < 10 ? nc : 10) - 1);
                    end
                    window_query(r, c, 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // stimulus
    initial
    begin
        pixel_op_t op;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: sample extremes passed through at radius zero
        write_reg(CFG_ROWS, 64);
        write_reg(CFG_COLS, 64);
        write_reg(CFG_RADIUS, 0);
        op = random_op(ACT_WRITE_SAMPLE);
        op.row = 63; op.col = 63; op.channel = 1; op.sample_value = 24'sh800000;
        push_op(op);
        op.row = 0; op.col = 0; op.channel = 0; op.sample_value = 24'sh7fffff;
        push_op(op);
        op = random_op(ACT_QUERY);
        op.row = 63; op.col = 63; op.channel = 1;
        push_op(op);
        op.row = 0; op.col = 0; op.channel = 0;
        push_op(op);
        op = random_op(ACT_WRITE_LABEL);
        op.row = 0; op.col = 0; op.label = 8'hff;
        push_op(op);
        op.row = 63; op.col = 63; op.label = 8'h00;
        push_op(op);
        op = random_op(ACT_WRITE_WEIGHT);
        op.weight_index = 7; op.weight = 16'hffff;
        push_op(op);
        // off-frame writes and query on a small frame
        wait_drained();
        write_reg(CFG_ROWS, 1);
        write_reg(CFG_COLS, 1);
        op = random_op(ACT_WRITE_SAMPLE);
        op.row = 1; op.col = 0;
        push_op(op);
        op = random_op(ACT_WRITE_LABEL);
        op.row = 0; op.col = 63;
        push_op(op);
        op = random_op(ACT_QUERY);
        op.row = 63; op.col = 63;
        push_op(op);
        // zero weight sum: all weights zero
        run_phase(5, 9, 2, 40, 1'b1);

        run_phase(64, 64, 0, 150, 1'b0);
        run_phase(16, 16, 3, 250, 1'b0);
        run_phase(64, 64, 7, 300, 1'b0);
        run_phase(1, 1, 7, 80, 1'b0);
        run_phase(5, 9, 2, 200, 1'b0);
        run_phase(13, 64, 5, 250, 1'b0);
        run_phase(64, 1, 1, 120, 1'b0);
        run_phase(2, 64, 4, 160, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_label_aware_gaussian_blur_core: done, clean");
        else
            $display("tb_label_aware_gaussian_blur_core: done, errors");
        $finish;
    end

    // idling is off for one long stretch of the run
    function automatic bit take_break();
        if (cycle_count > 30000 && cycle_count < 60000)
            return 1'b0;
        return $urandom_range(0, 99) < 32;
    endfunction

    // input transaction bookkeeping and cycle count
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_fire <= in_valid && in_ready;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_ops.size() != 0 && !take_break())
            begin
                pixel_op_t op;
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                action <= op.action;
                row <= op.row;
                col <= op.col;
                channel <= op.channel;
                sample_value <= op.sample_value;
                label <= op.label;
                weight_index <= op.weight_index;
                weight <= op.weight;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= !take_break();
    end

    // monitor
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result status", status, -1);
            end
            else
            begin
                blur_result_t want;
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (blurred_value !== want.blurred_value)
                    report_mismatch("blurred_value", blurred_value, want.blurred_value);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > 40000)
        begin
            $display("tb_label_aware_gaussian_blur_core: done, errors");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/core/lagb_pkg.sv
rtl/core/lagb_ram.sv
rtl/core/label_aware_gaussian_blur_core.sv
rtl/core/lagb_checker.sv
bench/tb_label_aware_gaussian_blur_core.sv
